>>> hw/rtl/dchf_pkg.sv
// Package for the clone-hit filter: beat structs, status codes, constants,
// controller/datapath command and status structs. No dependencies.
`default_nettype none
package dchf_pkg;

   localparam int unsigned CntW = 48;
   localparam logic [CntW-1:0] CntMax = {CntW{1'b1}};
   localparam logic [11:0] PacketBase = 12'd3001;

   typedef enum logic [1:0] {
      STAT_FIRST   = 2'd0,
      STAT_CLONE   = 2'd1,
      STAT_REJECT  = 2'd2,
      STAT_CLEARED = 2'd3
   } status_type;

   typedef struct packed {
      logic        kind;
      logic [11:0] packet_id;
      logic [3:0]  module_num;
      logic [4:0]  chip_num;
      logic [6:0]  channel_num;
      logic [3:0]  adc_value;
   } req_type;

   typedef struct packed {
      logic [1:0]      status;
      logic [2:0]      previous_adc;
      logic [CntW-1:0] ladder_clones;
      logic [CntW-1:0] ladder_hits_raw;
      logic [CntW-1:0] ladder_hits_unique;
      logic [CntW-1:0] type_a_total;
      logic [CntW-1:0] type_b_total;
   } rsp_type;

   // controller -> datapath
   typedef struct packed {
      logic load;      // capture input beat, start lookup
      logic update;    // apply counters, write store, fill rsp
      logic clr_start; // begin epoch bump / sweep
      logic clr_step;  // sweep one row
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic clr_done;
   } sts_type;

   // chip index 0-based: type B for 0..4 and 13..17
   function automatic logic chip_is_type_b(input logic [4:0] ci);
      return (ci <= 5'd4) || (ci >= 5'd13 && ci <= 5'd17);
   endfunction

   function automatic logic [CntW-1:0] sat_inc(input logic [CntW-1:0] v);
      return (v == CntMax) ? v : v + 1'b1;
   endfunction

endpackage
`default_nettype wire

>>> hw/rtl/dchf_datapath.sv
// Datapath of the clone-hit filter: channel store with epoch marks, ladder
// counter memories, type totals, result register. Uses dchf_pkg.
`default_nettype none
module dchf_datapath import dchf_pkg::*; #(
   parameter int unsigned PACKETS  = 8,
   parameter int unsigned MODULES  = 14,
   parameter int unsigned CHIPS    = 26,
   parameter int unsigned CHANNELS = 128
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire req_type req,
   input  wire cmd_type cmd,
   output sts_type      sts,
   output rsp_type      rsp
);

   localparam int unsigned Ladders = PACKETS * MODULES;
   localparam int unsigned Depth   = Ladders * CHIPS * CHANNELS;
   localparam int unsigned AddrW   = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int unsigned LadW    = (Ladders > 1) ? $clog2(Ladders) : 1;
   localparam int unsigned EpW     = 8;
   localparam logic [EpW-1:0] EpMax = {EpW{1'b1}};

   // entry: epoch mark + 3-bit ADC; valid when mark equals current epoch.
   // Live epochs run 1..EpMax, so a swept entry (mark 0) never matches.
   logic [EpW+2:0] store_mem [Depth];
   logic [CntW-1:0] clone_mem [Ladders];
   logic [CntW-1:0] raw_mem [Ladders];
   logic [CntW-1:0] uniq_mem [Ladders];

   logic [EpW-1:0]  epoch_ff, epoch_in;
   logic            sweep_ff, sweep_in;
   logic            lad_clr_ff, lad_clr_in;
   logic [AddrW-1:0] sweep_addr_ff, sweep_addr_in;
   logic [CntW-1:0] type_a_ff, type_a_in, type_b_ff, type_b_in;
   rsp_type         rsp_ff, rsp_in;

   // stage-1 captured hit
   logic             valid_hit_ff;
   logic             kind_ff;
   logic [AddrW-1:0] addr_ff;
   logic [LadW-1:0]  lad_ff;
   logic [2:0]       adc_ff;
   logic             typeb_ff;
   logic [EpW+2:0]   mark_rd_ff;
   logic [CntW-1:0]  clone_rd_ff, raw_rd_ff, uniq_rd_ff;

   logic [11:0] pi_w;
   logic [4:0]  ci_w;
   logic        ok_w;
   logic [LadW-1:0]  lad_w;
   logic [AddrW-1:0] addr_w;

   always_comb begin
      pi_w  = req.packet_id - PacketBase;
      ci_w  = req.chip_num - 5'd1;
      ok_w  = (req.packet_id >= PacketBase) && (pi_w < 12'(PACKETS)) &&
              (32'(req.module_num) < MODULES) && (req.chip_num != 5'd0) &&
              (32'(req.chip_num) <= CHIPS) && (32'(req.channel_num) < CHANNELS) &&
              !req.adc_value[3];
      lad_w  = LadW'(32'(pi_w) * MODULES + 32'(req.module_num));
      addr_w = AddrW'((32'(lad_w) * CHIPS + 32'(ci_w)) * CHANNELS
                      + 32'(req.channel_num));
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         valid_hit_ff <= ok_w && !req.kind;
         kind_ff      <= req.kind;
         addr_ff      <= addr_w;
         lad_ff       <= lad_w;
         adc_ff       <= req.adc_value[2:0];
         typeb_ff     <= chip_is_type_b(ci_w);
         mark_rd_ff   <= store_mem[addr_w];
         clone_rd_ff  <= clone_mem[lad_w];
         raw_rd_ff    <= raw_mem[lad_w];
         uniq_rd_ff   <= uniq_mem[lad_w];
      end
   end

   logic            hit_seen;
   logic [CntW-1:0] clone_nx, raw_nx, uniq_nx;
   logic            wr_store;
   logic [AddrW-1:0] wr_addr;
   logic [EpW+2:0]  wr_data;

   always_comb begin
      hit_seen = (mark_rd_ff[EpW+2:3] == epoch_ff);
      clone_nx = hit_seen ? sat_inc(clone_rd_ff) : clone_rd_ff;
      uniq_nx  = hit_seen ? uniq_rd_ff : sat_inc(uniq_rd_ff);
      raw_nx   = sat_inc(raw_rd_ff);
      type_a_in = type_a_ff;
      type_b_in = type_b_ff;
      rsp_in    = rsp_ff;
      epoch_in  = epoch_ff;
      sweep_in  = sweep_ff;
      lad_clr_in = lad_clr_ff;
      sweep_addr_in = sweep_addr_ff;
      wr_store = 1'b0;
      wr_addr  = addr_ff;
      wr_data  = {epoch_ff, adc_ff};
      if (cmd.update) begin
         rsp_in = '0;
         if (kind_ff) begin
            rsp_in.status = STAT_CLEARED;
         end else if (!valid_hit_ff) begin
            rsp_in.status = STAT_REJECT;
         end else begin
            wr_store = 1'b1;
            if (hit_seen) begin
               rsp_in.status       = STAT_CLONE;
               rsp_in.previous_adc = mark_rd_ff[2:0];
            end else begin
               rsp_in.status = STAT_FIRST;
               if (typeb_ff) type_b_in = sat_inc(type_b_ff);
               else          type_a_in = sat_inc(type_a_ff);
            end
            rsp_in.ladder_clones      = clone_nx;
            rsp_in.ladder_hits_raw    = raw_nx;
            rsp_in.ladder_hits_unique = uniq_nx;
         end
         rsp_in.type_a_total = type_a_in;
         rsp_in.type_b_total = type_b_in;
      end
      // end of event: bump epoch; on wrap, sweep store back to mark 0
      if (cmd.clr_start) begin
         if (epoch_ff == EpMax) begin
            epoch_in = EpW'(1);
            sweep_in = 1'b1;
            sweep_addr_in = '0;
         end else begin
            epoch_in = epoch_ff + 1'b1;
         end
      end
      if (cmd.clr_step && sweep_ff) begin
         wr_store = 1'b1;
         wr_addr  = sweep_addr_ff;
         wr_data  = '0;
         if (32'(sweep_addr_ff) == Depth - 1) begin
            sweep_in   = 1'b0;
            lad_clr_in = 1'b0;
         end else begin
            sweep_addr_in = sweep_addr_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (wr_store) store_mem[wr_addr] <= wr_data;
   end

   // ladder counters: cleared row by row during the reset sweep only
   always_ff @(posedge clock) begin
      if (cmd.clr_step && sweep_ff && lad_clr_ff && 32'(sweep_addr_ff) < Ladders) begin
         clone_mem[LadW'(sweep_addr_ff)] <= '0;
         raw_mem[LadW'(sweep_addr_ff)]   <= '0;
         uniq_mem[LadW'(sweep_addr_ff)]  <= '0;
      end else if (cmd.update && valid_hit_ff) begin
         clone_mem[lad_ff] <= clone_nx;
         raw_mem[lad_ff]   <= raw_nx;
         uniq_mem[lad_ff]  <= uniq_nx;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         epoch_ff      <= EpW'(1);
         sweep_ff      <= 1'b1;   // reset sweep: store and counters to empty
         lad_clr_ff    <= 1'b1;
         sweep_addr_ff <= '0;
         type_a_ff     <= '0;
         type_b_ff     <= '0;
      end else begin
         epoch_ff      <= epoch_in;
         sweep_ff      <= sweep_in;
         lad_clr_ff    <= lad_clr_in;
         sweep_addr_ff <= sweep_addr_in;
         type_a_ff     <= type_a_in;
         type_b_ff     <= type_b_in;
      end
   end

   always_ff @(posedge clock) rsp_ff <= rsp_in;

   assign rsp = rsp_ff;
   assign sts.clr_done = !sweep_ff;

`ifndef SYNTHESIS
   a_no_update_in_sweep: assert property (@(posedge clock) disable iff (reset)
      cmd.clr_step |-> !cmd.update) else $error("update during sweep");
   a_first_hit_no_adc: assert property (@(posedge clock) disable iff (reset)
      rsp_ff.status == STAT_FIRST |-> rsp_ff.previous_adc == 3'd0)
      else $error("first hit carries adc");
   a_type_mono: assert property (@(posedge clock) disable iff (reset)
      type_a_ff >= $past(type_a_ff)) else $error("type A total went down");
`endif

endmodule
`default_nettype wire

>>> hw/rtl/dchf_ctrl.sv
// Controller of the clone-hit filter: sweep wait, lookup/update sequence,
// result hold. Uses dchf_pkg.
`default_nettype none
module dchf_ctrl import dchf_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   input  wire logic    req_kind,
   input  wire sts_type sts,
   output cmd_type      cmd
);

   typedef enum logic [3:0] {
      ST_SWEEP  = 4'b0001,
      ST_IDLE   = 4'b0010,
      ST_LOOKUP = 4'b0100,
      ST_HOLD   = 4'b1000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      take;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      cmd          = '0;
      take         = 1'b0;
      req_stall    = 1'b1;
      if (rsp_valid_ff && !rsp_stall) rsp_valid_in = 1'b0;
      unique case (state_ff)
         ST_SWEEP: begin
            cmd.clr_step = 1'b1;
            if (sts.clr_done) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            req_stall = 1'b0;
            take      = req_valid;
            cmd.load  = take;
            if (take) state_in = ST_LOOKUP;
         end
         ST_LOOKUP: begin
            // result register must be free before update overwrites it
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.update   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_HOLD;
            end
         end
         ST_HOLD: begin
            state_in = ST_IDLE;
         end
         default: state_in = ST_SWEEP;
      endcase
      if (take && req_kind) cmd.clr_start = 1'b1;
      if (state_ff == ST_HOLD && !sts.clr_done) state_in = ST_SWEEP;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_SWEEP;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

`ifndef SYNTHESIS
   a_one_load: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> !cmd.load) else $error("back-to-back load");
   a_update_sets_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.update |=> rsp_valid) else $error("update without result");
   a_no_take_in_sweep: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SWEEP |-> req_stall) else $error("accept during sweep");
`endif

endmodule
`default_nettype wire

>>> hw/rtl/detector_clone_hit_filter_core.sv
// Top level of the clone-hit filter: controller plus datapath.
// Uses dchf_pkg, dchf_ctrl, dchf_datapath.
//
//  channel | ports                              | beat moves when
//  req     | req_valid, req_stall, req_data     | req_valid && !req_stall
//  rsp     | rsp_valid, rsp_stall, rsp_data     | rsp_valid && !rsp_stall
//
// Each item passes accept with store/counter read, then update with
// write-back, then a turnaround so the next read sees that write.
// After reset the store is swept, all PACKETS*MODULES*CHIPS*CHANNELS entries
// (372736 by default); no beat is accepted meanwhile.
// End of event bumps an 8-bit epoch; every 255th one repeats that sweep.
// A stalled result holds its register; the next item waits at update.
`default_nettype none
module detector_clone_hit_filter_core import dchf_pkg::*; #(
   parameter int unsigned PACKETS  = 8,
   parameter int unsigned MODULES  = 14,
   parameter int unsigned CHIPS    = 26,
   parameter int unsigned CHANNELS = 128
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_data
);

   cmd_type cmd;
   sts_type sts;

   dchf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .req_kind  (req_data.kind),
      .sts       (sts),
      .cmd       (cmd)
   );

   dchf_datapath #(
      .PACKETS  (PACKETS),
      .MODULES  (MODULES),
      .CHIPS    (CHIPS),
      .CHANNELS (CHANNELS)
   ) u_dp (
      .clock (clock),
      .reset (reset),
      .req   (req_data),
      .cmd   (cmd),
      .sts   (sts),
      .rsp   (rsp_data)
   );

endmodule
`default_nettype wire
